// ===== rtl/core/srrb_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the sentence receive ring buffer.
// No dependencies; used by srrb_cell and sentence_receive_ring_buffer.
package srrb_pkg;

  // Item kinds on the input channel
  typedef enum logic {
    OP_RX   = 1'b0,
    OP_POLL = 1'b1
  } opcode_t;

  // Framing characters
  localparam logic [7:0] CH_START = 8'h24;  // '$'
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned WAIT_W  = 6;

  // Per-cell control from the pointer logic
  typedef struct packed {
    logic shift;  // take the neighbour's byte (pop)
    logic load;   // take the received byte (push into this slot)
  } cell_ctl_t;

endpackage

// ===== rtl/core/sentence_receive_ring_buffer.sv =====
`timescale 1ns / 1ps
// Sentence-framing receive buffer: top level with the fill counter and result register.
// Depends on srrb_pkg and srrb_cell.
//
// The buffer holds up to DEPTH-1 received bytes in a row of byte cells, oldest at
// cell 0. A received byte is written into the first free cell; a pop hands every
// cell's byte to its neighbour toward cell 0 and returns what cell 0 held. A '$'
// empties the buffer and opens a sentence before being stored; CR or LF closes it
// and is still stored. A byte arriving with DEPTH-1 bytes held empties the buffer,
// is dropped and reports overflowed. A poll does nothing while no sentence is open;
// while one is open it pops one byte when cfg consumer_present is 1, or empties
// the buffer when it is 0. Every item yields exactly one result, carrying the fill
// count (low six bits) and the sentence flag after the item. The block accepts one
// item per cycle unless in_stall is high: the fill counter update and the cell shift
// or load all complete together, and the result register takes the next item as
// the previous result is drained (in_stall rises only when that register is full and
// out_stall is high). Emptying the buffer only clears the fill counter, so no
// clearing pass is needed after reset. The user must write consumer_present through
// cfg_wr_en/cfg_wr_data only while the block is idle; the block does not enforce it.
module sentence_receive_ring_buffer #(
  parameter int unsigned DEPTH = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  // input channel
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_opcode,
  input  logic [7:0] in_rx_byte,
  // result channel
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_read_valid,
  output logic [7:0] out_read_byte,
  output logic       out_read_empty,
  output logic       out_overflowed,
  output logic [5:0] out_bytes_waiting,
  output logic       out_in_message,
  // configuration
  input  logic       cfg_wr_en,
  input  logic       cfg_wr_data
);
  import srrb_pkg::*;

  localparam int unsigned NCELL = DEPTH - 1;
  localparam int unsigned CW    = $clog2(DEPTH);

  // Control state
  logic [CW-1:0] count_r, count_nxt;
  logic          open_r, open_nxt;
  logic          consumer_r;
  logic          out_valid_r, out_valid_nxt;

  // Result register (payload)
  logic          rd_valid_r, rd_valid_nxt;
  logic [7:0]    rd_byte_r, rd_byte_nxt;
  logic          rd_empty_r, rd_empty_nxt;
  logic          ovf_r, ovf_nxt;
  logic [5:0]    waiting_r, waiting_nxt;
  logic          msg_r;

  logic          accept;
  logic          do_push;
  logic          do_pop;
  logic [CW-1:0] push_slot;
  logic [CW+5:0] count_ext;

  // Cell chain wiring
  logic [7:0]    chain_byte [NCELL+1];

  // Transfer happens when the result register is free or being drained
  assign in_stall = out_valid_r & out_stall;
  assign accept   = in_valid & ~in_stall;

  always_comb begin
    count_nxt    = count_r;
    open_nxt     = open_r;
    do_push      = 1'b0;
    do_pop       = 1'b0;
    push_slot    = count_r;
    rd_valid_nxt = 1'b0;
    rd_byte_nxt  = '0;
    rd_empty_nxt = 1'b0;
    ovf_nxt      = 1'b0;
    if (in_opcode == OP_RX) begin
      // '$' opens a sentence on an emptied buffer
      if (in_rx_byte == CH_START) begin
        count_nxt = '0;
        open_nxt  = 1'b1;
      end else if (in_rx_byte == CH_LF || in_rx_byte == CH_CR) begin
        open_nxt  = 1'b0;
      end
      // first free cell after any emptying by '$'
      push_slot = count_nxt;
      if (count_nxt == CW'(NCELL)) begin
        // Full: drop the byte and empty the buffer
        count_nxt = '0;
        ovf_nxt   = 1'b1;
      end else begin
        do_push   = 1'b1;
        count_nxt = count_nxt + CW'(1);
      end
    end else if (open_r) begin
      if (consumer_r) begin
        if (count_r == '0) begin
          rd_empty_nxt = 1'b1;
        end else begin
          // Pop the oldest byte from cell 0 and advance the chain
          do_pop       = 1'b1;
          rd_valid_nxt = 1'b1;
          rd_byte_nxt  = chain_byte[0];
          count_nxt    = count_r - CW'(1);
        end
      end else begin
        // No consumer: drop everything held
        count_nxt = '0;
      end
    end
    count_ext   = {6'b0, count_nxt};
    waiting_nxt = count_ext[5:0];
  end

  // Row of byte cells; cell i loads when it is the first free slot
  assign chain_byte[NCELL] = '0;

  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    cell_ctl_t ctl;
    always_comb begin
      ctl.shift = accept & do_pop;
      ctl.load  = accept & do_push & (push_slot == CW'(i));
    end
    srrb_cell u_cell (
      .clk          (clk),
      .ctl_i        (ctl),
      .rx_byte_i    (in_rx_byte),
      .neigh_byte_i (chain_byte[i+1]),
      .byte_o       (chain_byte[i])
    );
  end

  // Result valid: hold until the transfer completes, reload on each accept
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (~out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      open_r      <= 1'b0;
      consumer_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (accept) begin
        count_r <= count_nxt;
        open_r  <= open_nxt;
      end
      if (cfg_wr_en) begin
        consumer_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_valid_r <= rd_valid_nxt;
      rd_byte_r  <= rd_byte_nxt;
      rd_empty_r <= rd_empty_nxt;
      ovf_r      <= ovf_nxt;
      waiting_r  <= waiting_nxt;
      msg_r      <= open_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_read_valid    = rd_valid_r;
  assign out_read_byte     = rd_byte_r;
  assign out_read_empty    = rd_empty_r;
  assign out_overflowed    = ovf_r;
  assign out_bytes_waiting = waiting_r;
  assign out_in_message    = msg_r;

  // At most one event flag per result
  a_one_event: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $onehot0({out_read_valid, out_read_empty, out_overflowed}))
    else $error("more than one event flag in a result");

  // A pop only happens inside an open sentence
  a_pop_open: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_read_valid) |-> out_in_message)
    else $error("byte popped outside a sentence");

  // An overflow leaves the buffer empty
  a_ovf_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_overflowed) |-> (out_bytes_waiting == 6'd0 && count_r == '0))
    else $error("overflow did not empty the buffer");

  // A poll with no consumer inside a sentence drops everything
  a_flush: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_opcode == OP_POLL && open_r && !consumer_r) |=> (count_r == '0))
    else $error("flush left bytes in the buffer");

  // The fill count never exceeds the cell count
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(NCELL))
    else $error("fill count beyond capacity");

endmodule

// ===== rtl/core/srrb_cell.sv =====
`timescale 1ns / 1ps
// One storage cell of the byte chain: holds a byte, shifts toward the head on pop.
// Depends on srrb_pkg.
module srrb_cell (
  input  logic              clk,
  input  srrb_pkg::cell_ctl_t ctl_i,
  input  logic [7:0]        rx_byte_i,
  input  logic [7:0]        neigh_byte_i,
  output logic [7:0]        byte_o
);
  import srrb_pkg::*;

  logic [BYTE_W-1:0] byte_r;
  logic [BYTE_W-1:0] byte_nxt;

  always_comb begin
    byte_nxt = byte_r;
    if (ctl_i.shift) begin
      byte_nxt = neigh_byte_i;
    end else if (ctl_i.load) begin
      byte_nxt = rx_byte_i;
    end
  end

  // Payload only: no reset
  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
  end

  assign byte_o = byte_r;

endmodule

// ===== sim/sentence_receive_ring_buffer_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for sentence_receive_ring_buffer: driver, monitor and ring predictor.
// Depends on srrb_pkg and the sentence_receive_ring_buffer RTL, including srrb_cell.
module sentence_receive_ring_buffer_tb;
  import srrb_pkg::*;

  localparam int unsigned RING_DEPTH  = 64;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned MAX_REPORTS = 10;

  // One input transfer as queued for the driver
  typedef struct {
    opcode_t    op;
    logic [7:0] data;
  } rx_item_t;

  // One result transfer, field for field as the block reports it
  typedef struct packed {
    logic       read_valid;
    logic [7:0] read_byte;
    logic       read_empty;
    logic       overflowed;
    logic [5:0] bytes_waiting;
    logic       in_message;
  } ring_result_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic       in_opcode = 1'b0;
  logic [7:0] in_rx_byte = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       out_read_valid;
  logic [7:0] out_read_byte;
  logic       out_read_empty;
  logic       out_overflowed;
  logic [5:0] out_bytes_waiting;
  logic       out_in_message;
  logic       cfg_wr_en = 1'b0;
  logic       cfg_wr_data = 1'b0;

  sentence_receive_ring_buffer #(
    .DEPTH(RING_DEPTH)
  ) i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_opcode        (in_opcode),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_read_valid   (out_read_valid),
    .out_read_byte    (out_read_byte),
    .out_read_empty   (out_read_empty),
    .out_overflowed   (out_overflowed),
    .out_bytes_waiting(out_bytes_waiting),
    .out_in_message   (out_in_message),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data)
  );

  // Pending input transfers, filled by the sequence and drained by the driver
  rx_item_t     rx_items[$];
  // Expected results, oldest first
  ring_result_t expected_results[$];

  // Predictor copy of the ring, its pointers, the sentence flag and the register
  logic [7:0] ring_bytes [RING_DEPTH];
  logic [5:0] ring_head;
  logic [5:0] ring_tail;
  logic       sentence_flag;
  logic       consumer_cfg;

  // Handshake profile: percentage of cycles each side idles
  int unsigned tx_idle_pct = 14;
  int unsigned rx_idle_pct = 47;

  bit          in_taken = 1'b0;
  int unsigned cycle_count = 0;
  int unsigned mismatch_count = 0;
  int unsigned stray_count = 0;
  int unsigned checked_count = 0;
  int unsigned pop_count = 0;
  int unsigned empty_pop_count = 0;
  int unsigned overflow_count = 0;
  int unsigned flush_count = 0;
  int unsigned queued_count = 0;

  // 12 ns clock
  initial begin
    forever #6 clk = ~clk;
  end

  // Work out the result of one accepted item and advance the predictor state.
  function automatic ring_result_t predict_ring(input opcode_t op, input logic [7:0] data);
    ring_result_t res;
    logic [5:0]   next_head;
    res = '0;
    if (op == OP_RX) begin
      // a start character empties the ring first, then is stored like any other byte
      if (data == CH_START) begin
        ring_head     = ring_tail;
        sentence_flag = 1'b1;
      end else if (data == CH_LF || data == CH_CR) begin
        sentence_flag = 1'b0;
      end
      next_head = ring_head + 6'd1;
      if (next_head == ring_tail) begin
        // full ring: empty it and drop the byte
        ring_head      = ring_tail;
        res.overflowed = 1'b1;
      end else begin
        ring_head             = next_head;
        ring_bytes[next_head] = data;
      end
    end else if (sentence_flag) begin
      if (consumer_cfg) begin
        if (ring_head == ring_tail) begin
          res.read_empty = 1'b1;
        end else begin
          ring_tail      = ring_tail + 6'd1;
          res.read_byte  = ring_bytes[ring_tail];
          res.read_valid = 1'b1;
        end
      end else begin
        // no consumer attached: drop everything held
        ring_head = ring_tail;
      end
    end
    res.bytes_waiting = ring_head - ring_tail;
    res.in_message    = sentence_flag;
    return res;
  endfunction

  // Monitor: sample both channels and the register port at the rising edge.
  always @(posedge clk) begin
    ring_result_t exp_res;
    ring_result_t act_res;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results still expected",
               cycle_count, expected_results.size());
      $display("FAILURE");
      $finish;
    end
    if (!rst_n) begin
      ring_head     = '0;
      ring_tail     = '0;
      sentence_flag = 1'b0;
      consumer_cfg  = 1'b0;
      in_taken      = 1'b0;
      expected_results.delete();
    end else begin
      if (cfg_wr_en) begin
        consumer_cfg = cfg_wr_data;
      end
      // queue the prediction before checking, so a result in the same cycle as its item would still match
      in_taken = in_valid && !in_stall;
      if (in_taken) begin
        expected_results.push_back(predict_ring(opcode_t'(in_opcode), in_rx_byte));
      end
      if (out_valid && !out_stall) begin
        act_res = '{out_read_valid, out_read_byte, out_read_empty, out_overflowed,
                    out_bytes_waiting, out_in_message};
        if (expected_results.size() == 0) begin
          stray_count++;
          if (mismatch_count + stray_count <= MAX_REPORTS) begin
            $display("Unexpected result at cycle %0d: %p", cycle_count, act_res);
          end
        end else begin
          exp_res = expected_results.pop_front();
          checked_count++;
          pop_count       += act_res.read_valid;
          empty_pop_count += act_res.read_empty;
          overflow_count  += act_res.overflowed;
          if (exp_res !== act_res) begin
            mismatch_count++;
            if (mismatch_count + stray_count <= MAX_REPORTS) begin
              $display("Mismatch at cycle %0d", cycle_count);
              $display("  expected rv=%b byte=%h empty=%b ovf=%b waiting=%0d msg=%b",
                       exp_res.read_valid, exp_res.read_byte, exp_res.read_empty,
                       exp_res.overflowed, exp_res.bytes_waiting, exp_res.in_message);
              $display("  actual   rv=%b byte=%h empty=%b ovf=%b waiting=%0d msg=%b",
                       act_res.read_valid, act_res.read_byte, act_res.read_empty,
                       act_res.overflowed, act_res.bytes_waiting, act_res.in_message);
            end
          end
        end
      end
    end
  end

  // Driver: change inputs at the falling edge. Hold a presented transfer until it
  // is taken, then advance to the next pending item or idle.
  always @(negedge clk) begin
    rx_item_t item;
    out_stall <= ($urandom_range(99) < rx_idle_pct);
    if (rst_n && (!in_valid || in_taken)) begin
      if (rx_items.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
        item = rx_items.pop_front();
        in_valid   <= 1'b1;
        in_opcode  <= item.op;
        in_rx_byte <= item.data;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  task automatic queue_item(input opcode_t op, input logic [7:0] data);
    rx_item_t item;
    item.op   = op;
    item.data = data;
    rx_items.push_back(item);
    queued_count++;
  endtask

  // Sentence body byte: steer clear of the framing characters
  function automatic logic [7:0] body_byte();
    logic [7:0] b;
    b = 8'($urandom_range(255));
    if (b == CH_START || b == CH_LF || b == CH_CR) begin
      b = b ^ 8'h40;
    end
    return b;
  endfunction

  // Well-formed sentence with random body and polls mixed in; long ones overflow the ring.
  task automatic queue_sentence(input bit force_long);
    bit          long_one;
    int unsigned len;
    int unsigned poll_pct;
    long_one = force_long || ($urandom_range(9) == 0);
    len      = long_one ? $urandom_range(80, 64) : $urandom_range(20, 1);
    poll_pct = long_one ? 0 : $urandom_range(60, 10);
    queue_item(OP_RX, CH_START);
    repeat (len) begin
      if ($urandom_range(99) < poll_pct) begin
        queue_item(OP_POLL, 8'($urandom_range(255)));
      end
      queue_item(OP_RX, body_byte());
    end
    // drain some of it while the sentence is still open, often past empty
    repeat ($urandom_range(6)) queue_item(OP_POLL, 8'($urandom_range(255)));
    // now and then leave the sentence unterminated
    if ($urandom_range(9) != 0) begin
      queue_item(OP_RX, $urandom_range(1) ? CH_CR : CH_LF);
    end
  endtask

  // Noise: arbitrary bytes with the framing characters favoured, and stray polls
  task automatic queue_noise();
    logic [7:0] b;
    repeat ($urandom_range(8, 1)) begin
      case ($urandom_range(9))
        0:       b = CH_START;
        1:       b = CH_CR;
        2:       b = CH_LF;
        default: b = 8'($urandom_range(255));
      endcase
      queue_item(($urandom_range(3) == 0) ? OP_POLL : OP_RX, b);
    end
  endtask

  task automatic queue_random(input int unsigned n_items);
    int unsigned stop_at;
    stop_at = queued_count + n_items;
    @(posedge clk);
    queue_sentence(1'b1);
    while (queued_count < stop_at) begin
      if ($urandom_range(99) < 80) begin
        queue_sentence(1'b0);
      end else begin
        queue_noise();
      end
    end
  endtask

  // Block until every pending item is taken and every result has arrived
  task automatic wait_drained();
    do @(negedge clk); while (rx_items.size() != 0 || in_valid || expected_results.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_consumer(input logic value);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // Sequence: directed checks, then three random phases with differing register
  // values and handshake profiles.
  initial begin
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    tx_idle_pct = 14;
    rx_idle_pct = 47;
    write_consumer(1'b1);
    @(posedge clk);
    queue_item(OP_POLL, 8'hFF);    // poll with no sentence open: ignored
    queue_item(OP_RX, 8'h00);      // bytes before any start are still stored
    queue_item(OP_RX, 8'hFF);
    queue_item(OP_RX, CH_START);   // empty the ring and open a sentence
    queue_item(OP_RX, 8'hA5);
    queue_item(OP_RX, 8'h5A);
    repeat (3) queue_item(OP_POLL, 8'h00);  // pop the start and both bytes
    queue_item(OP_POLL, 8'h00);    // pop from an empty ring
    queue_item(OP_RX, CH_CR);      // close, still stored
    queue_item(OP_POLL, 8'h00);    // closed: nothing happens
    queue_item(OP_RX, CH_START);
    queue_item(OP_RX, 8'h7F);
    queue_item(OP_RX, CH_LF);
    queue_item(OP_RX, CH_START);
    queue_item(OP_RX, 8'h80);
    wait_drained();

    write_consumer(1'b0);
    @(posedge clk);
    queue_item(OP_POLL, 8'h00);    // no consumer: flush the open sentence
    queue_item(OP_POLL, 8'hFF);    // flush while already empty
    queue_item(OP_RX, 8'h55);
    queue_item(OP_POLL, 8'hAA);
    wait_drained();

    // random phase one: consumer attached, receiver stalls heavily
    write_consumer(1'b1);
    queue_random(370);
    wait_drained();

    // random phase two: no consumer, sender idles heavily
    tx_idle_pct = 47;
    rx_idle_pct = 14;
    write_consumer(1'b0);
    queue_random(370);
    wait_drained();

    // random phase three: consumer attached, back-to-back transfers
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    write_consumer(1'b1);
    queue_random(370);
    wait_drained();

    flush_count = queued_count - checked_count;
    $display("Checked %0d results from %0d items over three handshake profiles:",
             checked_count, queued_count);
    $display("  %0d pops, %0d empty pops, %0d overflows; %0d mismatches, %0d stray results",
             pop_count, empty_pop_count, overflow_count, mismatch_count, stray_count);
    if (mismatch_count == 0 && stray_count == 0 && expected_results.size() == 0 &&
        flush_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
